[rtl/dhg_pkg.sv]
// Shared widths, constants and types of the double Henyey-Greenstein phase block.
`timescale 1ns / 1ps
package dhg_pkg;

    localparam int GW        = 16;
    localparam int VW        = 16;
    localparam int PW        = 2 * VW;
    localparam int CW        = 33;
    localparam int GGW       = 31;
    localparam int GCW       = GW + CW;
    localparam int BASEW     = 50;
    localparam int BASE_SH   = 7;
    localparam int BW        = 41;
    localparam int SW        = 21;
    localparam int BLO       = SW;
    localparam int KW        = 29;
    localparam int AW        = 59;
    localparam int DW        = 62;
    localparam int QW        = 32;
    localparam int FRAC_EXTRA = 8;
    localparam int AHI_LSB   = QW - FRAC_EXTRA;
    localparam int ONE_BASE_SH = 43;
    localparam int ONE_NUM_SH  = 30;
    localparam int GG_SH       = 13;
    localparam int MW        = 17;
    localparam int ACCW      = MW + QW;
    localparam int ROUND_SH  = 16;

    localparam logic [KW-1:0] INV_FOUR_PI = 29'd341782638;
    localparam logic [MW-1:0] MIX_ONE     = 17'd65536;

    typedef struct packed {
        logic valid;
        logic clip;
    } lobe_ctl_t;

    typedef enum logic [1:0] {
        REG_ASYM_ONE = 2'd0,
        REG_ASYM_TWO = 2'd1,
        REG_LOBE_MIX = 2'd2
    } cfg_index_t;

endpackage

[rtl/dhg_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module dhg_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  dhg_pkg::lobe_ctl_t       in_ctl,
    input  logic [dhg_pkg::BW-1:0]   in_b,
    input  logic [dhg_pkg::AW-1:0]   in_a,
    output dhg_pkg::lobe_ctl_t       out_ctl,
    output logic [dhg_pkg::SW-1:0]   out_s,
    output logic [dhg_pkg::BW-1:0]   out_b,
    output logic [dhg_pkg::AW-1:0]   out_a
);
    import dhg_pkg::*;

    localparam int TW = BW + 2;

    lobe_ctl_t      ctl_reg  [SW];
    logic [SW-1:0]  root_reg [SW];
    logic [BW-1:0]  rem_reg  [SW];
    logic [BW-1:0]  b_reg    [SW];
    logic [AW-1:0]  a_reg    [SW];

    for (genvar j = 0; j < SW; j++) begin : g_stage
        localparam int K = SW - 1 - j;
        lobe_ctl_t     ctl_in;
        logic [SW-1:0] root_in;
        logic [BW-1:0] rem_in;
        logic [BW-1:0] b_in;
        logic [AW-1:0] a_in;
        logic [TW-1:0] trial;
        logic          take;
        logic [SW-1:0] root_next;
        logic [BW-1:0] rem_next;

        if (j == 0) begin : g_first
            assign ctl_in  = in_ctl;
            assign root_in = '0;
            assign rem_in  = in_b;
            assign b_in    = in_b;
            assign a_in    = in_a;
        end else begin : g_rest
            assign ctl_in  = ctl_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign b_in    = b_reg[j-1];
            assign a_in    = a_reg[j-1];
        end

        always_comb
        begin
            trial     = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
            take      = TW'(rem_in) >= trial;
            root_next = take ? (root_in | (SW'(1) << K)) : root_in;
            rem_next  = take ? BW'(TW'(rem_in) - trial) : rem_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                ctl_reg[j] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= root_next;
                rem_reg[j]  <= rem_next;
                b_reg[j]    <= b_in;
                a_reg[j]    <= a_in;
            end
        end
    end

    assign out_ctl = ctl_reg[SW-1];
    assign out_s   = root_reg[SW-1];
    assign out_b   = b_reg[SW-1];
    assign out_a   = a_reg[SW-1];

endmodule

[rtl/dhg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module dhg_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  dhg_pkg::lobe_ctl_t       in_ctl,
    input  logic [dhg_pkg::DW-1:0]   in_d,
    input  logic [dhg_pkg::DW-1:0]   in_rem,
    input  logic [dhg_pkg::QW-1:0]   in_nlo,
    output dhg_pkg::lobe_ctl_t       out_ctl,
    output logic [dhg_pkg::QW-1:0]   out_q
);
    import dhg_pkg::*;

    lobe_ctl_t      ctl_reg [QW];
    logic [DW-1:0]  d_reg   [QW];
    logic [DW-1:0]  rem_reg [QW];
    logic [QW-1:0]  nlo_reg [QW];
    logic [QW-1:0]  q_reg   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        lobe_ctl_t     ctl_in;
        logic [DW-1:0] d_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] nlo_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] nlo_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign ctl_in = in_ctl;
            assign d_in   = in_d;
            assign rem_in = in_rem;
            assign nlo_in = in_nlo;
            assign q_in   = '0;
        end else begin : g_rest
            assign ctl_in = ctl_reg[j-1];
            assign d_in   = d_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign nlo_in = nlo_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        always_comb
        begin
            rem_sh   = {rem_in, nlo_in[QW-1]};
            ge       = rem_sh >= {1'b0, d_in};
            rem_next = ge ? DW'(rem_sh - {1'b0, d_in}) : rem_sh[DW-1:0];
            nlo_next = nlo_in << 1;
            q_next   = {q_in[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                ctl_reg[j] <= ctl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j]   <= d_in;
                rem_reg[j] <= rem_next;
                nlo_reg[j] <= nlo_next;
                q_reg[j]   <= q_next;
            end
        end
    end

    assign out_ctl = ctl_reg[QW-1];
    assign out_q   = q_reg[QW-1];

endmodule

[rtl/dhg_lobe.sv]
// One Henyey-Greenstein lobe: base, square root, denominator product and division.
`timescale 1ns / 1ps
module dhg_lobe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [dhg_pkg::CW-1:0]  cos_q,
    input  logic signed [dhg_pkg::GW-1:0]  asym,
    output dhg_pkg::lobe_ctl_t             out_ctl,
    output logic [dhg_pkg::QW-1:0]         lobe
);
    import dhg_pkg::*;

    logic                   v1_reg;
    logic signed [GCW-1:0]  gc_reg;
    logic [GGW-1:0]         gg_reg;
    logic signed [GCW-1:0]  gc_next;
    logic signed [PW-1:0]   gg_full;

    lobe_ctl_t              ctl2_reg;
    logic [BW-1:0]          b_reg;
    logic [AW-1:0]          a_reg;
    logic signed [BASEW-1:0] base;
    logic [GGW-1:0]         num;
    logic [KW+GGW-1:0]      a_full;
    lobe_ctl_t              ctl2_next;

    lobe_ctl_t              sq_ctl;
    logic [SW-1:0]          sq_s;
    logic [BW-1:0]          sq_b;
    logic [AW-1:0]          sq_a;

    lobe_ctl_t              ctlm1_reg;
    logic [BLO+SW-1:0]      plo_reg;
    logic [BW-BLO+SW-1:0]   phi_reg;
    logic [AW-1:0]          am1_reg;

    lobe_ctl_t              ctlm2_reg;
    logic [DW-1:0]          d_reg;
    logic [AW-1:0]          am2_reg;

    lobe_ctl_t              ctlm3_reg;
    logic [DW-1:0]          dm3_reg;
    logic [DW-1:0]          rem_reg;
    logic [QW-1:0]          nlo_reg;
    logic [DW-1:0]          ahi;
    lobe_ctl_t              ctlm3_next;

    lobe_ctl_t              div_ctl;
    logic [QW-1:0]          div_q;

    always_comb
    begin
        gc_next = asym * cos_q;
        gg_full = asym * asym;
    end

    always_comb
    begin
        base = (BASEW'(1) << ONE_BASE_SH) + (BASEW'(gg_reg) << GG_SH)
             - (BASEW'(gc_reg) << 1);
        num  = (GGW'(1) << ONE_NUM_SH) - gg_reg;
        a_full = INV_FOUR_PI * num;
        ctl2_next.valid = v1_reg;
        ctl2_next.clip  = base[BASEW-1] || (base[BASEW-2:BASE_SH] == '0);
    end

    always_comb
    begin
        ahi = DW'(am2_reg[AW-1:AHI_LSB]);
        ctlm3_next.valid = ctlm2_reg.valid;
        ctlm3_next.clip  = ctlm2_reg.clip || (ahi >= d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            ctl2_reg  <= '0;
            ctlm1_reg <= '0;
            ctlm2_reg <= '0;
            ctlm3_reg <= '0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            ctl2_reg  <= ctl2_next;
            ctlm1_reg <= sq_ctl;
            ctlm2_reg <= ctlm1_reg;
            ctlm3_reg <= ctlm3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gc_reg  <= gc_next;
            gg_reg  <= gg_full[GGW-1:0];
            b_reg   <= base[BW+BASE_SH-1:BASE_SH];
            a_reg   <= a_full[AW-1:0];
            plo_reg <= sq_b[BLO-1:0] * sq_s;
            phi_reg <= sq_b[BW-1:BLO] * sq_s;
            am1_reg <= sq_a;
            d_reg   <= (DW'(phi_reg) << BLO) + DW'(plo_reg);
            am2_reg <= am1_reg;
            dm3_reg <= d_reg;
            rem_reg <= ahi;
            nlo_reg <= {am2_reg[AHI_LSB-1:0], FRAC_EXTRA'(0)};
        end
    end

    dhg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ctl2_reg),
        .in_b    (b_reg),
        .in_a    (a_reg),
        .out_ctl (sq_ctl),
        .out_s   (sq_s),
        .out_b   (sq_b),
        .out_a   (sq_a)
    );

    dhg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ctlm3_reg),
        .in_d    (dm3_reg),
        .in_rem  (rem_reg),
        .in_nlo  (nlo_reg),
        .out_ctl (div_ctl),
        .out_q   (div_q)
    );

    assign out_ctl = div_ctl;
    assign lobe    = div_ctl.clip ? '1 : div_q;

endmodule

[rtl/double_henyey_greenstein_phase.sv]
// Top level of the double Henyey-Greenstein phase block: dot product, two lobes, blend, output.
`timescale 1ns / 1ps
// The block takes one request per clock while the pipeline is not held by a full output
// buffer. The two lobe pipelines run side by side and each have a 21-stage square root
// and a 32-stage divider; the dot product registers come before them, and the blend and
// output registers after them. A two-entry output buffer lets new requests enter while
// one result waits. When both entries are full, the whole pipeline holds until the output
// side takes a result. Configuration
// registers may only be written while no request is in flight.
module double_henyey_greenstein_phase (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  in_x,
    input  logic signed [15:0]  in_y,
    input  logic signed [15:0]  in_z,
    input  logic signed [15:0]  out_x,
    input  logic signed [15:0]  out_y,
    input  logic signed [15:0]  out_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         density,
    output logic                saturated
);
    import dhg_pkg::*;

    logic signed [GW-1:0] asym_one_reg;
    logic signed [GW-1:0] asym_two_reg;
    logic [MW-1:0]        lobe_mix_reg;

    logic                 en;
    logic                 t1_valid_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [PW-1:0] pz_reg;
    logic                 t2_valid_reg;
    logic signed [CW-1:0] cos_reg;

    lobe_ctl_t            ctl_one;
    lobe_ctl_t            ctl_two;
    logic [QW-1:0]        lobe_one;
    logic [QW-1:0]        lobe_two;

    logic [MW-1:0]        w1;
    logic [MW-1:0]        w2;
    logic                 b1_valid_reg;
    logic [ACCW-1:0]      m1_reg;
    logic [ACCW-1:0]      m2_reg;
    logic                 flag_reg;
    logic [ACCW-1:0]      acc;

    logic                 o_valid_reg;
    logic                 o_valid_next;
    logic [QW-1:0]        o_density_reg;
    logic [QW-1:0]        o_density_next;
    logic                 o_sat_reg;
    logic                 o_sat_next;
    logic                 k_valid_reg;
    logic                 k_valid_next;
    logic [QW-1:0]        k_density_reg;
    logic [QW-1:0]        k_density_next;
    logic                 k_sat_reg;
    logic                 k_sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asym_one_reg <= '0;
            asym_two_reg <= '0;
            lobe_mix_reg <= MIX_ONE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ASYM_ONE: asym_one_reg <= cfg_data[GW-1:0];
                REG_ASYM_TWO: asym_two_reg <= cfg_data[GW-1:0];
                REG_LOBE_MIX: lobe_mix_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !k_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            b1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= in_valid;
            t2_valid_reg <= t1_valid_reg;
            b1_valid_reg <= ctl_one.valid;
        end
    end

    always_comb
    begin
        w1 = (lobe_mix_reg > MIX_ONE) ? MIX_ONE : lobe_mix_reg;
        w2 = MIX_ONE - w1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= in_x * out_x;
            py_reg   <= in_y * out_y;
            pz_reg   <= in_z * out_z;
            cos_reg  <= CW'(px_reg) + CW'(py_reg) + CW'(pz_reg);
            m1_reg   <= w1 * lobe_one;
            m2_reg   <= w2 * lobe_two;
            flag_reg <= (ctl_one.clip && (w1 != '0)) || (ctl_two.clip && (w2 != '0));
        end
    end

    dhg_lobe u_lobe_one (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (t2_valid_reg),
        .cos_q    (cos_reg),
        .asym     (asym_one_reg),
        .out_ctl  (ctl_one),
        .lobe     (lobe_one)
    );

    dhg_lobe u_lobe_two (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (t2_valid_reg),
        .cos_q    (cos_reg),
        .asym     (asym_two_reg),
        .out_ctl  (ctl_two),
        .lobe     (lobe_two)
    );

    assign acc = m1_reg + m2_reg + (ACCW'(1) << (ROUND_SH - 1));

    always_comb
    begin
        o_valid_next   = o_valid_reg;
        o_density_next = o_density_reg;
        o_sat_next     = o_sat_reg;
        k_valid_next   = k_valid_reg;
        k_density_next = k_density_reg;
        k_sat_next     = k_sat_reg;
        if (!o_valid_reg || out_ready)
        begin
            if (k_valid_reg)
            begin
                o_valid_next   = 1'b1;
                o_density_next = k_density_reg;
                o_sat_next     = k_sat_reg;
                k_valid_next   = 1'b0;
            end
            else
            begin
                o_valid_next   = b1_valid_reg;
                o_density_next = acc[QW+ROUND_SH-1:ROUND_SH];
                o_sat_next     = flag_reg;
            end
        end
        else if (en && b1_valid_reg)
        begin
            k_valid_next   = 1'b1;
            k_density_next = acc[QW+ROUND_SH-1:ROUND_SH];
            k_sat_next     = flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
            k_valid_reg <= k_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_density_reg <= o_density_next;
        o_sat_reg     <= o_sat_next;
        k_density_reg <= k_density_next;
        k_sat_reg     <= k_sat_next;
    end

    assign out_valid = o_valid_reg;
    assign density   = o_density_reg;
    assign saturated = o_sat_reg;

    a_skid_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        k_valid_reg |-> o_valid_reg)
        else $error("buffered result present without an output result");

    a_lobes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_one.valid == ctl_two.valid)
        else $error("lobe pipelines out of step");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !out_ready && en && b1_valid_reg) |=> k_valid_reg)
        else $error("result lost while output stalled");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (k_valid_reg && out_ready) |=> (!k_valid_reg && o_valid_reg))
        else $error("buffered result not moved to output");

endmodule

[dv/dhg_checker.sv]
// Checker for the double Henyey-Greenstein phase block: predicts each result and compares.
`timescale 1ns / 1ps
module dhg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_z,
    input  logic signed [15:0] out_x,
    input  logic signed [15:0] out_y,
    input  logic signed [15:0] out_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [31:0]        density,
    input  logic               saturated,
    output int                 errors,
    output int                 pending
);
    import dhg_pkg::*;

    logic signed [15:0] g_one;
    logic signed [15:0] g_two;
    logic [16:0]        mix_weight;
    logic [32:0]        expected_density[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Returns {clipped, lobe value in Q16.16}.
    function automatic logic [32:0] hg_lobe(logic signed [15:0] g, longint cosq);
        longint          gl;
        longint          gg;
        longint          base;
        longint unsigned b;
        longint unsigned d;
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        gl   = g;
        gg   = gl * gl;
        base = (longint'(1) << 43) + gg * 8192 - 2 * gl * cosq;
        if (base <= 0)
            return {1'b1, 32'hFFFF_FFFF};
        b = longint'(base) >>> 7;
        if (b == 0)
            return {1'b1, 32'hFFFF_FFFF};
        d = b * int_sqrt(b);
        a = 64'd341782638 * ((64'd1 << 30) - gg);
        q = a / d;
        r = a % d;
        if (q >= (64'd1 << 32))
            return {1'b1, 32'hFFFF_FFFF};
        for (int i = 0; i < 8; i++)
        begin
            q = q << 1;
            r = r << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q + 1;
            end
        end
        if (q >= (64'd1 << 32))
            return {1'b1, 32'hFFFF_FFFF};
        return {1'b0, q[31:0]};
    endfunction

    // Returns {saturated, density}.
    function automatic logic [32:0] blended_density();
        longint          cosq;
        logic [32:0]     l1;
        logic [32:0]     l2;
        longint unsigned w1;
        longint unsigned w2;
        longint unsigned acc;
        logic            flag;
        cosq = longint'(in_x) * out_x + longint'(in_y) * out_y + longint'(in_z) * out_z;
        l1   = hg_lobe(g_one, cosq);
        l2   = hg_lobe(g_two, cosq);
        w1   = (mix_weight > 17'd65536) ? 64'd65536 : 64'(mix_weight);
        w2   = 64'd65536 - w1;
        acc  = w1 * l1[31:0] + w2 * l2[31:0] + 64'd32768;
        flag = (l1[32] && w1 != 0) || (l2[32] && w2 != 0);
        return {flag, acc[47:16]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [32:0] exp_item;
        if (!rst_n)
        begin
            g_one      = '0;
            g_two      = '0;
            mix_weight = 17'd65536;
            expected_density.delete();
            errors     = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_density.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: density %h saturated %b",
                                 density, saturated);
                end
                else
                begin
                    exp_item = expected_density.pop_front();
                    if (exp_item[31:0] !== density || exp_item[32] !== saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected density %h saturated %b, got %h %b",
                                     exp_item[31:0], exp_item[32], density, saturated);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_density = {expected_density, blended_density()};
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_ASYM_ONE: g_one = cfg_data[15:0];
                    REG_ASYM_TWO: g_two = cfg_data[15:0];
                    REG_LOBE_MIX: mix_weight = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_density.size();
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench top for the double Henyey-Greenstein phase block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
    import dhg_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] in_x, in_y, in_z, out_x, out_y, out_z;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        density;
    logic               saturated;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    double_henyey_greenstein_phase u_top (.*);

    dhg_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("tb_top: errors");
        $finish;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_request(input logic signed [15:0] ix, iy, iz, ox, oy, oz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_x <= ix; in_y <= iy; in_z <= iz;
        out_x <= ox; out_y <= oy; out_z <= oz;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic signed [15:0] rand_component();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // Waits for the pipeline to drain, then writes all registers plus an unused index.
    task automatic set_lobes(input logic [16:0] g1, g2, mix);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_write <= 1'b1; cfg_index <= REG_ASYM_ONE; cfg_data <= g1;
        @(posedge clk);
        cfg_index <= REG_ASYM_TWO; cfg_data <= g2;
        @(posedge clk);
        cfg_index <= REG_LOBE_MIX; cfg_data <= mix;
        @(posedge clk);
        cfg_index <= REG_UNUSED; cfg_data <= 17'($urandom_range(17'h1FFFF));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [16:0]        g1, g2, mix;
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0;
        in_x = '0; in_y = '0; in_z = '0; out_x = '0; out_y = '0; out_z = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: single lobe with g of zero.
        send_request(16384, 16384, 16384, 16384, 16384, 16384);
        send_request(-16384, 0, 0, 16384, 0, 0);

        // Strong forward lobe against full backward lobe, half blend.
        set_lobes(17'h07FFF, 17'h08000, 17'd32768);
        send_request(16384, 16384, 16384, 16384, 16384, 16384);
        send_request(-16384, -16384, -16384, 16384, 16384, 16384);
        send_request(16384, -16384, 16384, -16384, 16384, -16384);
        send_request(0, 0, 0, 0, 0, 0);
        send_request(16384, 0, 0, 16384, 0, 0);
        send_request(0, 16384, 0, 0, -16384, 0);
        send_request(0, 0, 16384, 0, 0, 8192);
        send_request(-1, -1, -1, 1, 1, 1);
        send_request(16383, 16383, 16383, 16383, 16383, 16383);
        send_request(12000, 9000, 0, 12000, 9000, 0);

        // Weight entirely on lobe two, then a mix above one.
        set_lobes(17'h07FFF, 17'h08000, 17'd0);
        send_request(16384, 16384, 16384, 16384, 16384, 16384);
        send_request(-16384, -16384, -16384, 16384, 16384, 16384);
        send_request(5000, -3000, 7000, 100, 200, -300);
        set_lobes(17'h08000, 17'h07FFF, 17'h1FFFF);
        send_request(16384, 16384, 16384, 16384, 16384, 16384);
        send_request(-16384, -16384, -16384, 16384, 16384, 16384);
        send_request(5000, -3000, 7000, 100, 200, -300);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin g1 = 17'h07FFF; g2 = 17'h08000; mix = 17'd65536; end
                1: begin g1 = 17'h00000; g2 = 17'h04000; mix = 17'd0; end
                2: begin g1 = 17'h0C000; g2 = 17'h03000; mix = 17'd32768; end
                3: begin g1 = 17'h08000; g2 = 17'h07FFF; mix = 17'h1FFFF; end
                default:
                begin
                    g1 = 17'($urandom_range(16'hFFFF));
                    g2 = 17'($urandom_range(16'hFFFF));
                    mix = 17'($urandom_range(65536));
                end
            endcase
            set_lobes(g1, g2, mix);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < 250; n++)
                send_request(rand_component(), rand_component(), rand_component(),
                             rand_component(), rand_component(), rand_component());
        end

        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
